// ----- rtl/core/rrfc_pkg.sv -----
// ---------------------------------------------------------------------------
// rrfc_pkg
// Shared types and codes for the request retry / failover client.
// ---------------------------------------------------------------------------
`default_nettype none

package rrfc_pkg;

   typedef enum logic [1:0] {
      OP_SEND         = 2'd0,
      OP_TICK         = 2'd1,
      OP_LOOKUP_REPLY = 2'd2,
      OP_RESPONSE     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      RCLASS_OK        = 2'd0,
      RCLASS_EXCEPTION = 2'd1,
      RCLASS_BAD       = 2'd2
   } reply_class_type;

   typedef enum logic [2:0] {
      ACT_NONE     = 3'd0,
      ACT_TRANSMIT = 3'd1,
      ACT_LOOKUP   = 3'd2,
      ACT_SUCCESS  = 3'd3,
      ACT_FAILURE  = 3'd4,
      ACT_REFUSED  = 3'd5,
      ACT_QUEUED   = 3'd6,
      ACT_DROPPED  = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      CAUSE_NONE      = 2'd0,
      CAUSE_LOST_CONN = 2'd1,
      CAUSE_TIMEOUT   = 2'd2,
      CAUSE_EXCEPTION = 2'd3
   } cause_type;

   typedef enum logic [1:0] {
      REG_RETRY_LIMIT    = 2'd0,
      REG_LOOKUP_AFTER   = 2'd1,
      REG_REPLY_TIMEOUT  = 2'd2,
      REG_FAILOVER_HOSTS = 2'd3
   } csr_reg_type;

   localparam logic [3:0]  RETRY_LIMIT_RST    = 4'd5;
   localparam logic [3:0]  LOOKUP_AFTER_RST   = 4'd3;
   localparam logic [15:0] REPLY_TIMEOUT_RST  = 16'd5;
   localparam logic [3:0]  FAILOVER_HOSTS_RST = 4'd0;

   typedef struct packed {
      logic [3:0]  retry_limit;
      logic [3:0]  lookup_after;
      logic [15:0] reply_timeout;
      logic [3:0]  failover_hosts;
   } cfg_type;

   // classified event as it travels from front to back
   typedef struct packed {
      op_type          op;
      logic            peer_alive;
      logic            lookup_failed;
      reply_class_type rclass;
   } ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/core/rrfc_front.sv -----
// ---------------------------------------------------------------------------
// rrfc_front
// Accepts events, decodes them and holds them in a two-entry queue for the
// back end.
// ---------------------------------------------------------------------------
`default_nettype none

module rrfc_front #(
   parameter int SEQ_BITS  = 16,
   parameter int TIME_BITS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_cmd,
   input  wire logic [TIME_BITS-1:0] req_now,
   input  wire logic                 req_peer_alive,
   input  wire logic                 req_lookup_failed,
   input  wire logic [SEQ_BITS-1:0]  req_reply_seq,
   input  wire logic [1:0]           req_reply_kind,
   output logic                      deq_valid,
   input  wire logic                 deq_pop,
   output rrfc_pkg::ctrl_type        deq_ctrl,
   output logic [TIME_BITS-1:0]      deq_now,
   output logic [SEQ_BITS-1:0]       deq_seq
);
   import rrfc_pkg::*;

   localparam int DEPTH = 2;

   ctrl_type             ctrl_q [DEPTH];
   logic [TIME_BITS-1:0] now_q  [DEPTH];
   logic [SEQ_BITS-1:0]  seq_q  [DEPTH];

   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   ctrl_type   ctrl_dec;

   always_comb begin
      ctrl_dec.op            = op_type'(req_cmd);
      ctrl_dec.peer_alive    = req_peer_alive;
      ctrl_dec.lookup_failed = req_lookup_failed;
      case (req_reply_kind)
         2'd0:    ctrl_dec.rclass = RCLASS_OK;
         2'd1:    ctrl_dec.rclass = RCLASS_EXCEPTION;
         default: ctrl_dec.rclass = RCLASS_BAD;
      endcase
   end

   assign req_stall = (count_ff == 2'(DEPTH));
   assign push      = req_valid && !req_stall;
   assign deq_valid = (count_ff != 2'd0);
   assign deq_ctrl  = ctrl_q[rd_ptr_ff];
   assign deq_now   = now_q[rd_ptr_ff];
   assign deq_seq   = seq_q[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = (deq_pop && deq_valid) ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(deq_pop && deq_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ctrl_q[wr_ptr_ff] <= ctrl_dec;
         now_q[wr_ptr_ff]  <= req_now;
         seq_q[wr_ptr_ff]  <= req_reply_seq;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/rrfc_back.sv -----
// ---------------------------------------------------------------------------
// rrfc_back
// Request state machine: retry counting, host failover, timeout and
// response matching, one event per cycle into a result register unless it is stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module rrfc_back #(
   parameter int SEQ_BITS  = 16,
   parameter int TIME_BITS = 32,
   parameter int MAX_HOSTS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rrfc_pkg::cfg_type    cfg,
   input  wire logic                 deq_valid,
   output logic                      deq_pop,
   input  wire rrfc_pkg::ctrl_type   deq_ctrl,
   input  wire logic [TIME_BITS-1:0] deq_now,
   input  wire logic [SEQ_BITS-1:0]  deq_seq,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [2:0]                rsp_action,
   output logic [1:0]                rsp_fail_cause,
   output logic [SEQ_BITS-1:0]       rsp_seq_out,
   output logic [3:0]                rsp_host_index
);
   import rrfc_pkg::*;

   localparam int CMP_W = (TIME_BITS > 16) ? TIME_BITS : 16;

   logic                 pending_ff, pending_in;
   logic                 connected_ff, connected_in;
   logic [4:0]           retry_ff, retry_in;
   logic [3:0]           fpos_ff, fpos_in;
   logic [SEQ_BITS-1:0]  seq_ff, seq_in;
   logic [TIME_BITS-1:0] sent_at_ff, sent_at_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   action_type           act_ff, act_in;
   cause_type            cause_ff, cause_in;
   logic [SEQ_BITS-1:0]  seq_out_ff;
   logic [3:0]           host_ff, host_in;

   logic [4:0]           retry_inc;
   logic [3:0]           hosts_eff;
   logic [4:0]           pos_next;
   logic [TIME_BITS-1:0] elapsed;
   logic                 overdue;
   logic                 close_req;

   assign deq_pop   = deq_valid && (!rsp_valid_ff || !rsp_stall);
   assign retry_inc = retry_ff + 5'd1;
   assign hosts_eff = (cfg.failover_hosts > 4'(MAX_HOSTS)) ? 4'(MAX_HOSTS)
                                                           : cfg.failover_hosts;
   assign pos_next  = {1'b0, fpos_ff} + 5'd1;
   // modular age of the outstanding request
   assign elapsed   = deq_now - sent_at_ff;
   assign overdue   = CMP_W'(elapsed) > CMP_W'(cfg.reply_timeout);

   always_comb begin
      pending_in   = pending_ff;
      connected_in = connected_ff;
      retry_in     = retry_ff;
      fpos_in      = fpos_ff;
      seq_in       = seq_ff;
      sent_at_in   = sent_at_ff;
      act_in       = ACT_NONE;
      cause_in     = CAUSE_NONE;
      host_in      = 4'd0;
      close_req    = 1'b0;

      case (deq_ctrl.op)
         OP_SEND: begin
            if (pending_ff) begin
               act_in = ACT_REFUSED;
            end else begin
               pending_in = 1'b1;
               if (connected_ff && deq_ctrl.peer_alive) begin
                  sent_at_in = deq_now;
                  act_in     = ACT_TRANSMIT;
               end else begin
                  act_in = ACT_QUEUED;
               end
            end
         end
         OP_TICK: begin
            if (!connected_ff || !deq_ctrl.peer_alive) begin
               connected_in = 1'b0;
               retry_in     = retry_inc;
               if (retry_inc > {1'b0, cfg.retry_limit}) begin
                  retry_in = 5'd0;
                  if (pending_ff) begin
                     close_req = 1'b1;
                     act_in    = ACT_FAILURE;
                     cause_in  = CAUSE_LOST_CONN;
                  end
               end else if (retry_inc > {1'b0, cfg.lookup_after}) begin
                  retry_in = 5'd0;
                  act_in   = ACT_LOOKUP;
                  // round-robin over default host and failover list
                  if (hosts_eff != 4'd0) begin
                     fpos_in = (pos_next > {1'b0, hosts_eff}) ? 4'd0 : pos_next[3:0];
                     host_in = fpos_in;
                  end
               end
            end else if (pending_ff && overdue) begin
               retry_in = retry_inc;
               if (retry_inc > {1'b0, cfg.retry_limit}) begin
                  close_req = 1'b1;
                  act_in    = ACT_FAILURE;
                  cause_in  = CAUSE_TIMEOUT;
               end else begin
                  sent_at_in = deq_now;
                  act_in     = ACT_TRANSMIT;
               end
            end
         end
         OP_LOOKUP_REPLY: begin
            retry_in = 5'd0;
            if (!connected_ff && !deq_ctrl.lookup_failed) begin
               connected_in = 1'b1;
               if (pending_ff) begin
                  sent_at_in = deq_now;
                  act_in     = ACT_TRANSMIT;
               end
            end
         end
         OP_RESPONSE: begin
            if (deq_seq == seq_ff) begin
               close_req = 1'b1;
               case (deq_ctrl.rclass)
                  RCLASS_OK: begin
                     act_in = ACT_SUCCESS;
                  end
                  RCLASS_EXCEPTION: begin
                     act_in   = ACT_FAILURE;
                     cause_in = CAUSE_EXCEPTION;
                  end
                  default: begin
                     act_in = ACT_DROPPED;
                  end
               endcase
            end else begin
               act_in = ACT_DROPPED;
            end
         end
         default: begin
            act_in = ACT_NONE;
         end
      endcase

      if (close_req) begin
         pending_in = 1'b0;
         sent_at_in = '0;
         retry_in   = 5'd0;
         seq_in     = seq_ff + SEQ_BITS'(1);
      end

      rsp_valid_in = deq_pop ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         connected_ff <= 1'b0;
         retry_ff     <= 5'd0;
         fpos_ff      <= 4'd0;
         seq_ff       <= '0;
         sent_at_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (deq_pop) begin
            pending_ff   <= pending_in;
            connected_ff <= connected_in;
            retry_ff     <= retry_in;
            fpos_ff      <= fpos_in;
            seq_ff       <= seq_in;
            sent_at_ff   <= sent_at_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (deq_pop) begin
         act_ff     <= act_in;
         cause_ff   <= cause_in;
         seq_out_ff <= seq_ff;
         host_ff    <= host_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_action     = act_ff;
   assign rsp_fail_cause = cause_ff;
   assign rsp_seq_out    = seq_out_ff;
   assign rsp_host_index = host_ff;

   a_cause_only_on_failure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (act_ff == ACT_FAILURE) || (cause_ff == CAUSE_NONE))
      else $error("fail cause set on a non-failure beat");

   a_host_only_on_lookup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (act_ff == ACT_LOOKUP) || (host_ff == 4'd0))
      else $error("host index set on a non-lookup beat");

   a_failover_pos_range: assert property (@(posedge clock) disable iff (reset)
      fpos_ff <= 4'(MAX_HOSTS))
      else $error("failover position beyond host list");

   a_close_clears_pending: assert property (@(posedge clock) disable iff (reset)
      (deq_pop && close_req) |=> !pending_ff && (retry_ff == 5'd0))
      else $error("closed request still pending");

endmodule

`default_nettype wire

// ----- rtl/core/request_retry_failover_client.sv -----
// ---------------------------------------------------------------------------
// request_retry_failover_client
// Stop-and-wait request client with retry, reply timeout and host failover.
//
// Events enter on the req_ channel (send, wakeup tick, lookup reply,
// response); each gives exactly one result beat on the rsp_ channel.
// A beat is taken at a clock edge where valid is high and stall is low.
// The front end decodes events into a two-entry queue; the back end holds
// the request state and updates it for one event per cycle while a valid
// result beat is not stalled. An event is written into the queue and, once
// the back end pops it, into the result register, where rsp_valid rises.
// When rsp_stall is high the result register holds, the queue fills and
// req_stall rises once both queue entries are in use.
// Synchronous reset empties the queue, drops any result, closes the
// request, clears the sequence number and loads the register defaults
// (retry limit 5, lookup after 3, reply timeout 5, no failover hosts).
// The user must write configuration over the APB port only while no event
// is in flight; the block does not enforce this. pready is always high.
// ---------------------------------------------------------------------------
`default_nettype none

module request_retry_failover_client #(
   parameter int SEQ_BITS  = 16,
   parameter int TIME_BITS = 32,
   parameter int MAX_HOSTS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_cmd,
   input  wire logic [TIME_BITS-1:0] req_now,
   input  wire logic                 req_peer_alive,
   input  wire logic                 req_lookup_failed,
   input  wire logic [SEQ_BITS-1:0]  req_reply_seq,
   input  wire logic [1:0]           req_reply_kind,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [2:0]                rsp_action,
   output logic [1:0]                rsp_fail_cause,
   output logic [SEQ_BITS-1:0]       rsp_seq_out,
   output logic [3:0]                rsp_host_index,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [3:0]           paddr,
   input  wire logic [31:0]          pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);
   import rrfc_pkg::*;

   cfg_type              cfg_ff, cfg_in;
   logic                 csr_write;
   csr_reg_type          csr_sel;

   logic                 deq_valid;
   logic                 deq_pop;
   ctrl_type             deq_ctrl;
   logic [TIME_BITS-1:0] deq_now;
   logic [SEQ_BITS-1:0]  deq_seq;

   assign pready    = 1'b1;
   assign csr_sel   = csr_reg_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_sel)
            REG_RETRY_LIMIT:    cfg_in.retry_limit    = pwdata[3:0];
            REG_LOOKUP_AFTER:   cfg_in.lookup_after   = pwdata[3:0];
            REG_REPLY_TIMEOUT:  cfg_in.reply_timeout  = pwdata[15:0];
            REG_FAILOVER_HOSTS: cfg_in.failover_hosts = pwdata[3:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         REG_RETRY_LIMIT:    prdata = {28'd0, cfg_ff.retry_limit};
         REG_LOOKUP_AFTER:   prdata = {28'd0, cfg_ff.lookup_after};
         REG_REPLY_TIMEOUT:  prdata = {16'd0, cfg_ff.reply_timeout};
         REG_FAILOVER_HOSTS: prdata = {28'd0, cfg_ff.failover_hosts};
         default:            prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.retry_limit    <= RETRY_LIMIT_RST;
         cfg_ff.lookup_after   <= LOOKUP_AFTER_RST;
         cfg_ff.reply_timeout  <= REPLY_TIMEOUT_RST;
         cfg_ff.failover_hosts <= FAILOVER_HOSTS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rrfc_front #(
      .SEQ_BITS  (SEQ_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_now           (req_now),
      .req_peer_alive    (req_peer_alive),
      .req_lookup_failed (req_lookup_failed),
      .req_reply_seq     (req_reply_seq),
      .req_reply_kind    (req_reply_kind),
      .deq_valid         (deq_valid),
      .deq_pop           (deq_pop),
      .deq_ctrl          (deq_ctrl),
      .deq_now           (deq_now),
      .deq_seq           (deq_seq)
   );

   rrfc_back #(
      .SEQ_BITS  (SEQ_BITS),
      .TIME_BITS (TIME_BITS),
      .MAX_HOSTS (MAX_HOSTS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .deq_valid      (deq_valid),
      .deq_pop        (deq_pop),
      .deq_ctrl       (deq_ctrl),
      .deq_now        (deq_now),
      .deq_seq        (deq_seq),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_action     (rsp_action),
      .rsp_fail_cause (rsp_fail_cause),
      .rsp_seq_out    (rsp_seq_out),
      .rsp_host_index (rsp_host_index)
   );

endmodule

`default_nettype wire
